[rtl/multi_symbol_range_encoder_macros.svh]
// Assertion helpers for the range encoder
`ifndef MULTI_SYMBOL_RANGE_ENCODER_MACROS_SVH
`define MULTI_SYMBOL_RANGE_ENCODER_MACROS_SVH

// property that must hold at every clock outside reset
`define MSRE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define MSRE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/msre_pkg.sv]
package msre_pkg;

   localparam int WindowBits = 32;

   typedef enum logic [2:0] {
      CMD_SYMBOL     = 3'd0,
      CMD_SYMBOL_Q15 = 3'd1,
      CMD_BOOL       = 3'd2,
      CMD_BOOL_Q15   = 3'd3,
      CMD_FLUSH      = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [14:0] cum_low;
      logic [15:0] cum_high;
      logic [15:0] total_freq;
      logic        bit_value;
      logic [14:0] zero_prob;
   } req_type;

   typedef struct packed {
      logic [8:0] carry_word;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_NORM,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture the item, do the first step
      logic map;      // compute u, v (from products in the Q15 modes)
      logic norm;     // renormalize, queue words
      logic flush_it; // one flush search step
      logic flush_end;// queue flush words, reset state
      logic pop;      // one queued word leaves
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic       is_flush;
      logic       is_valid_cmd;
      logic       flush_done;
      logic [1:0] words_left;
   } sts_type;

endpackage

[rtl/msre_ctrl.sv]
`include "multi_symbol_range_encoder_macros.svh"

module msre_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  msre_pkg::sts_type   sts,
   output msre_pkg::ctl_type   ctl
);

   msre_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msre_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         msre_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               if (sts.is_flush) begin
                  state_in = msre_pkg::ST_FLUSH;
               end else if (sts.is_valid_cmd) begin
                  state_in = msre_pkg::ST_MAP;
               end
            end
         end
         msre_pkg::ST_MAP: begin
            ctl.map  = 1'b1;
            state_in = msre_pkg::ST_NORM;
         end
         msre_pkg::ST_NORM: begin
            ctl.norm = 1'b1;
            state_in = msre_pkg::ST_EMIT;
         end
         msre_pkg::ST_FLUSH: begin
            if (sts.flush_done) begin
               ctl.flush_end = 1'b1;
               state_in      = msre_pkg::ST_EMIT;
            end else begin
               ctl.flush_it = 1'b1;
            end
         end
         msre_pkg::ST_EMIT: begin
            if (sts.words_left == 2'd0) begin
               state_in = msre_pkg::ST_IDLE;
            end else begin
               rsp_valid = 1'b1;
               if (rsp_ready) begin
                  ctl.pop = 1'b1;
                  if (sts.words_left == 2'd1) begin
                     state_in = msre_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: state_in = msre_pkg::ST_IDLE;
      endcase
   end

   `MSRE_ASSERT(a_ready_idle, !(req_ready && rsp_valid), "ready while result pending")
   `MSRE_ASSERT_NEXT(a_map_norm, state_ff == msre_pkg::ST_MAP, state_ff == msre_pkg::ST_NORM,
      "map not followed by normalize")
   `MSRE_ASSERT_NEXT(a_pop_last, ctl.pop && sts.words_left == 2'd1,
      state_ff == msre_pkg::ST_IDLE, "did not return idle after last word")

endmodule

[rtl/msre_datapath.sv]
`include "multi_symbol_range_encoder_macros.svh"

module msre_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   input  msre_pkg::req_type   req_payload,
   input  msre_pkg::ctl_type   ctl,
   output msre_pkg::sts_type   sts,
   output msre_pkg::rsp_type   rsp_payload
);

   localparam int W  = msre_pkg::WindowBits;
   localparam int WX = W + 17;

   logic            ro_ff;
   logic [W-1:0]    low_ff;
   logic [15:0]     rng_ff;
   logic [5:0]      cnt_ff;

   // captured item
   logic [2:0]      cmd_ff;
   logic            val_ff, sh_ff;
   logic [16:0]     ft_ff, d_ff;
   logic [16:0]     fa_ff, fb_ff;   // clamped bounds (fl, fh or fz)
   logic [31:0]     pa_ff, pb_ff;   // q15 products
   logic [W:0]      nl_ff;          // low to normalize
   logic [16:0]     nr_ff;          // range to normalize

   // flush search
   logic [W+1:0]    fl_ff;          // l + r
   logic [15:0]     m_ff;
   logic [6:0]      fs_ff;
   logic [W+1:0]    fe_c, fm_c;

   // output queue
   logic [8:0]      wq_ff [3];
   logic [1:0]      wn_ff, wr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ro_ff <= 1'b0;
      end else if (csr_write_enable) begin
         ro_ff <= csr_write_data;
      end
   end

   // ---------------- capture ----------------
   msre_pkg::req_type rq;
   logic [16:0] ft_c, ftc, fhc, flc, fzc, dsub, ftmax;
   logic        sh_c, q15;
   always_comb begin
      rq    = req_payload;
      q15   = (rq.cmd == msre_pkg::CMD_SYMBOL_Q15) || (rq.cmd == msre_pkg::CMD_BOOL_Q15);
      ft_c  = {1'b0, rq.total_freq};
      if (ft_c < 17'd16384) ft_c = 17'd16384;
      if (ft_c > 17'd32768) ft_c = 17'd32768;
      dsub  = {1'b0, rng_ff} - ft_c;
      sh_c  = !q15 && (dsub >= ft_c);
      ftc   = sh_c ? {ft_c[15:0], 1'b0} : ft_c;
      ftmax = q15 ? 17'd32768 : ft_c;
      fhc   = {1'b0, rq.cum_high};
      if (fhc < 17'd1) fhc = 17'd1;
      if (fhc > ftmax) fhc = ftmax;
      flc   = {2'b0, rq.cum_low};
      if (flc >= fhc) flc = fhc - 17'd1;
      fzc   = {2'b0, rq.zero_prob};
      if (fzc < 17'd1) fzc = 17'd1;
      if (fzc > ftmax - 17'd1) fzc = ftmax - 17'd1;
      if (rq.cmd == msre_pkg::CMD_BOOL || rq.cmd == msre_pkg::CMD_BOOL_Q15) begin
         flc = fzc;
      end
   end

   always_comb begin
      sts.is_flush     = (rq.cmd == msre_pkg::CMD_FLUSH);
      sts.is_valid_cmd = (rq.cmd <= msre_pkg::CMD_BOOL_Q15);
      sts.flush_done   = (m_ff == 16'd0) ||
                         ({{(W+2-16){1'b0}}, m_ff} | fe_c) < fl_ff;
      sts.words_left   = wn_ff - wr_ff;
   end

   // ---------------- map ----------------
   function automatic logic [16:0] map_s(input logic [16:0] f, input logic [16:0] d,
                                         input logic [16:0] ft, input logic ro);
      logic [17:0] e, a, b, g;
      begin
         e = ({d, 1'b0} > {1'b0, ft}) ? {d, 1'b0} - {1'b0, ft} : 18'd0;
         a = ({1'b0, f} < e) ? {1'b0, f} : e;
         g = ({1'b0, f} > e) ? ({1'b0, f} - e) >> 1 : 18'd0;
         b = (g < {1'b0, d}) ? g : {1'b0, d};
         if (ro) begin
            map_s = 17'(18'(f) + a + b);
         end else begin
            map_s = 17'(18'(f) + (({1'b0, f} < {1'b0, d}) ? {1'b0, f} : {1'b0, d}));
         end
      end
   endfunction

   logic [16:0] u_c, v_c;
   always_comb begin
      unique case (cmd_ff)
         msre_pkg::CMD_SYMBOL: begin
            u_c = map_s(sh_ff ? {fa_ff[15:0], 1'b0} : fa_ff, d_ff, ft_ff, ro_ff);
            v_c = map_s(sh_ff ? {fb_ff[15:0], 1'b0} : fb_ff, d_ff, ft_ff, ro_ff);
         end
         msre_pkg::CMD_BOOL: begin
            u_c = 17'd0;
            v_c = map_s(sh_ff ? {fa_ff[15:0], 1'b0} : fa_ff, d_ff, ft_ff, ro_ff);
         end
         msre_pkg::CMD_SYMBOL_Q15: begin
            u_c = pa_ff[31:15];
            v_c = pb_ff[31:15];
         end
         default: begin
            u_c = 17'd0;
            v_c = pa_ff[31:15];
         end
      endcase
   end

   // ---------------- normalize ----------------
   logic [4:0]  d_n;
   logic [6:0]  s_n, c_n;
   logic [W:0]  l_n;
   logic [8:0]  w0, w1;
   logic [1:0]  nw;
   always_comb begin
      d_n = 5'd16;
      for (int i = 0; i < 16; i++) begin
         if (nr_ff[i]) d_n = 5'(15 - i);
      end
      s_n = 7'({{1{cnt_ff[5]}}, cnt_ff}) + 7'(d_n);
      c_n = 7'({{1{cnt_ff[5]}}, cnt_ff}) + 7'd16;
      l_n = nl_ff;
      w0  = '0;
      w1  = '0;
      nw  = 2'd0;
      if (!s_n[6]) begin
         if (!s_n[6] && s_n >= 7'd8 && c_n >= 7'd8) begin
            w0  = 9'(l_n >> c_n[5:0]);
            l_n = l_n & ((W+1)'(({{W{1'b0}}, 1'b1} << c_n[5:0]) - 1));
            c_n = c_n - 7'd8;
            nw  = 2'd1;
         end
         if (nw == 2'd1) w1 = 9'(l_n >> c_n[5:0]);
         else            w0 = 9'(l_n >> c_n[5:0]);
         l_n = l_n & ((W+1)'(({{W{1'b0}}, 1'b1} << c_n[5:0]) - 1));
         s_n = c_n + 7'(d_n) - 7'd24;
         nw  = nw + 2'd1;
      end
   end

   // ---------------- flush ----------------
   always_comb begin
      fm_c = {{(W+2-16){1'b0}}, m_ff};
      fe_c = ({2'b0, low_ff} + fm_c) & ~fm_c;
   end

   logic [6:0]  fsum;
   logic [5:0]  fsh;
   logic [W+1:0] fe0, fe1;
   logic [8:0]  fw [3];
   logic [1:0]  fn;
   always_comb begin
      fsum = fs_ff + 7'({{1{cnt_ff[5]}}, cnt_ff});
      fsh  = 6'(cnt_ff + 6'd16);
      fe0  = fe_c;
      fn   = 2'd0;
      for (int k = 0; k < 3; k++) fw[k] = '0;
      if (!fsum[6] && fsum != 7'd0) begin
         // shift = c + 16 is in 7..15 when any word is emitted
         fe1 = fe0;
         for (int k = 0; k < 3; k++) begin
            if (!fsum[6] && fsum > 7'(8 * k)) begin
               if (fsh >= 6'(8 * k)) begin
                  fw[k] = 9'(fe1 >> (fsh - 6'(8 * k)));
                  fe1   = fe1 & ((W+2)'(({{(W+1){1'b0}}, 1'b1} << (fsh - 6'(8 * k))) - 1));
               end else begin
                  fw[k] = 9'(fe1 << (6'(8 * k) - fsh));
                  fe1   = '0;
               end
               fn = fn + 2'd1;
            end
         end
      end else begin
         fe1 = fe0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= '0;
         rng_ff <= 16'h8000;
         cnt_ff <= 6'h37;
         wn_ff  <= '0;
         wr_ff  <= '0;
      end else begin
         if (ctl.norm) begin
            low_ff <= W'(l_n << d_n);
            rng_ff <= 16'(nr_ff << d_n);
            cnt_ff <= s_n[5:0];
            wq_ff[0] <= w0;
            wq_ff[1] <= w1;
            wn_ff  <= nw;
            wr_ff  <= '0;
         end
         if (ctl.flush_end) begin
            low_ff <= '0;
            rng_ff <= 16'h8000;
            cnt_ff <= 6'h37;
            wq_ff[0] <= fw[0];
            wq_ff[1] <= fw[1];
            wq_ff[2] <= fw[2];
            wn_ff  <= fn;
            wr_ff  <= '0;
         end
         if (ctl.pop) wr_ff <= wr_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= rq.cmd;
         val_ff <= rq.bit_value;
         sh_ff  <= sh_c;
         ft_ff  <= ftc;
         d_ff   <= {1'b0, rng_ff} - ftc;
         fa_ff  <= flc;
         fb_ff  <= fhc;
         pa_ff  <= 32'(flc) * 32'(rng_ff);
         pb_ff  <= 32'(fhc) * 32'(rng_ff);
         fl_ff  <= (W+2)'(low_ff) + (W+2)'(rng_ff);
         m_ff   <= 16'h7FFF;
         fs_ff  <= 7'd9;
      end
      if (ctl.map) begin
         if (cmd_ff == msre_pkg::CMD_SYMBOL || cmd_ff == msre_pkg::CMD_SYMBOL_Q15) begin
            nl_ff <= (W+1)'(low_ff) + (W+1)'(u_c);
            nr_ff <= v_c - u_c;
         end else begin
            nl_ff <= val_ff ? (W+1)'(low_ff) + (W+1)'(v_c) : (W+1)'(low_ff);
            nr_ff <= val_ff ? {1'b0, rng_ff} - v_c : v_c;
         end
      end
      if (ctl.flush_it) begin
         m_ff  <= m_ff >> 1;
         fs_ff <= fs_ff + 7'd1;
      end
   end

   always_comb begin
      rsp_payload.carry_word = wq_ff[wr_ff];
      rsp_payload.last       = (wr_ff + 2'd1 == wn_ff);
   end

   `MSRE_ASSERT(a_range_norm, rng_ff[15], "range not normalized")
   `MSRE_ASSERT(a_queue, wr_ff <= wn_ff, "queue read past fill")
   `MSRE_ASSERT_NEXT(a_flush_reset, ctl.flush_end, rng_ff == 16'h8000 && low_ff == '0,
      "flush did not reset state")

endmodule

[rtl/multi_symbol_range_encoder.sv]
// channel | ports                       | direction
// req     | req_valid/req_ready/req_payload | in, one command item
// rsp     | rsp_valid/rsp_ready/rsp_payload | out, 9-bit pre-carry words
// csr     | csr_write_enable/csr_write_data | in, reduced_overhead
// Symbol and boolean items pass through capture (with products), map and
// normalize, then emit their result words; flush searches one mask bit per
// cycle, then emits its words. Unknown commands are taken in idle and give
// no words.
// Reset is synchronous, active high; state returns to range 0x8000.
// A stalled rsp holds the block; no new item is taken until all words leave.
module multi_symbol_range_encoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  msre_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output msre_pkg::rsp_type   rsp_payload,
   input  logic                csr_write_enable,
   input  logic                csr_write_data
);

   msre_pkg::ctl_type ctl;
   msre_pkg::sts_type sts;

   msre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   msre_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .ctl              (ctl),
      .sts              (sts),
      .rsp_payload      (rsp_payload)
   );

endmodule

[tb/sv/testbench.sv]
module testbench;

   localparam logic [2:0] CMD_RSVD_LO = 3'd5;
   localparam logic [2:0] CMD_RSVD_HI = 3'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 60;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   msre_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   msre_pkg::rsp_type rsp_payload;
   logic    csr_write_enable = 0;
   logic    csr_write_data = 0;

   multi_symbol_range_encoder uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // encoder state mirror
   longint unsigned low_win;
   int unsigned     range_q;
   int              bits_pending;
   bit              ro_mode;

   msre_pkg::rsp_type pending_words[$];
   int      failures = 0;
   int      words_seen = 0;
   int      items_sent = 0;
   int      flushes_sent = 0;
   int      cycles = 0;
   bit      long_hold = 0;
   bit      gaps_on = 1;

   typedef struct {
      msre_pkg::req_type item;
      bit         typed;
      int         nwords;
      logic [8:0] words[3];
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic void add_word(inout logic [8:0] w[3], inout int n,
                                    input longint unsigned v);
      if (n < 3) begin
         w[n] = v[8:0];
         n++;
      end
   endfunction

   function automatic int unsigned map_cum(int unsigned f, int unsigned d, int unsigned ft);
      int unsigned e, rest;
      if (ro_mode) begin
         e = (2 * d > ft) ? 2 * d - ft : 0;
         rest = (f > e) ? (f - e) >> 1 : 0;
         return f + ((f < e) ? f : e) + ((rest < d) ? rest : d);
      end
      return f + ((f < d) ? f : d);
   endfunction

   function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void renorm(longint unsigned l, int unsigned r,
                                  inout logic [8:0] w[3], inout int n);
      int bits, d, s, c;
      longint unsigned m;
      bits = 0;
      r &= 32'hFFFF;
      while (bits < 16 && (r >> bits) != 0) bits++;
      d = 16 - bits;
      s = bits_pending + d;
      if (s >= 0) begin
         c = (bits_pending + 16) & 63;
         m = (64'd1 << c) - 1;
         if (s >= 8 && c >= 8) begin
            add_word(w, n, l >> c);
            l &= m;
            c -= 8;
            m >>= 8;
         end
         add_word(w, n, l >> c);
         s = c + d - 24;
         l &= m;
      end
      low_win = (l << d) & 64'hFFFF_FFFF;
      range_q = (r << d) & 32'hFFFF;
      bits_pending = s;
   endfunction

   // returns the words one command produces and advances the mirror
   function automatic int encode_item(msre_pkg::req_type it, output logic [8:0] w[3]);
      int n, s, c, sh_n;
      int unsigned fl, fh, ft, fz, u, v, d, sh, r;
      longint unsigned l, m, e, nm, wv;
      n = 0;
      fl = it.cum_low;
      fh = it.cum_high;
      ft = it.total_freq;
      fz = it.zero_prob;
      l = low_win;
      r = range_q;
      w = '{default: '0};
      case (it.cmd)
         msre_pkg::CMD_SYMBOL, msre_pkg::CMD_BOOL: begin
            ft = clamp(ft, 16384, 32768);
            sh = (r - ft >= ft) ? 1 : 0;
            ft <<= sh;
            d = r - ft;
            if (it.cmd == msre_pkg::CMD_SYMBOL) begin
               fh = clamp(fh, 1, ft >> sh);
               if (fl >= fh) fl = fh - 1;
               u = map_cum(fl << sh, d, ft);
               v = map_cum(fh << sh, d, ft);
               renorm(l + u, v - u, w, n);
            end else begin
               fz = clamp(fz, 1, (ft >> sh) - 1) << sh;
               v = map_cum(fz, d, ft);
               if (it.bit_value) l += v;
               renorm(l, it.bit_value ? r - v : v, w, n);
            end
         end
         msre_pkg::CMD_SYMBOL_Q15: begin
            fh = clamp(fh, 1, 32768);
            if (fl >= fh) fl = fh - 1;
            u = 32'((64'(fl) * r) >> 15);
            v = 32'((64'(fh) * r) >> 15);
            renorm(l + u, v - u, w, n);
         end
         msre_pkg::CMD_BOOL_Q15: begin
            fz = clamp(fz, 1, 32767);
            v = 32'((64'(fz) * r) >> 15);
            if (it.bit_value) l += v;
            renorm(l, it.bit_value ? r - v : v, w, n);
         end
         msre_pkg::CMD_FLUSH: begin
            s = 9;
            c = bits_pending;
            m = 64'h7FFF;
            e = (l + m) & ~m;
            while (m != 0 && (e | m) >= l + r) begin
               s++;
               m >>= 1;
               e = (l + m) & ~m;
            end
            s += c;
            if (s > 0) begin
               sh_n = c + 16;
               nm = (sh_n > 0 && sh_n < 64) ? ((64'd1 << sh_n) - 1) : 0;
               do begin
                  wv = (sh_n >= 0) ? e >> sh_n : e << (-sh_n);
                  add_word(w, n, wv);
                  e &= nm;
                  s -= 8;
                  sh_n -= 8;
                  nm >>= 8;
               end while (s > 0 && n < 3);
            end
            low_win = 0;
            range_q = 32'h8000;
            bits_pending = -9;
         end
         default: ;
      endcase
      return n;
   endfunction

   function automatic void queue_words(logic [8:0] w[3], int n);
      msre_pkg::rsp_type x;
      for (int i = 0; i < n; i++) begin
         x.carry_word = w[i];
         x.last = (i == n - 1);
         pending_words.push_back(x);
      end
   endfunction

   function automatic msre_pkg::req_type mk_item(logic [2:0] cmd, logic [14:0] fl,
                                                 logic [15:0] fh, logic [15:0] ft,
                                                 logic bv, logic [14:0] zp);
      msre_pkg::req_type r;
      r.cmd = cmd;
      r.cum_low = fl;
      r.cum_high = fh;
      r.total_freq = ft;
      r.bit_value = bv;
      r.zero_prob = zp;
      return r;
   endfunction

   function automatic void add_row(msre_pkg::req_type it, bit typed);
      dir_row_type row;
      row.item = it;
      row.typed = typed;
      row.nwords = 0;
      row.words = '{default: '0};
      dir_rows.push_back(row);
   endfunction

   task automatic send_item(msre_pkg::req_type it, bit typed, int typed_n,
                            logic [8:0] typed_w[3]);
      int gap;
      int n;
      logic [8:0] w[3];
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_payload <= it;
      do @(posedge clock); while (!req_ready);
      n = encode_item(it, w);
      if (typed) queue_words(typed_w, typed_n);
      else queue_words(w, n);
      items_sent++;
      if (it.cmd == msre_pkg::CMD_FLUSH) flushes_sent++;
   endtask

   task automatic send_plain(msre_pkg::req_type it);
      logic [8:0] none[3];
      none = '{default: '0};
      send_item(it, 0, 0, none);
   endtask

   task automatic drain_and_idle();
      @(negedge clock);
      req_valid <= 0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(bit v);
      drain_and_idle();
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 0;
      ro_mode = v;
   endtask

   function automatic msre_pkg::req_type well_formed_item();
      msre_pkg::req_type r;
      int unsigned ft, fh, fl;
      r = '0;
      r.cmd = msre_pkg::cmd_type'($urandom_range(0, 3));
      ft = $urandom_range(16384, 32768);
      r.total_freq = ft;
      if (r.cmd == msre_pkg::CMD_SYMBOL_Q15) ft = 32768;
      fh = $urandom_range(1, ft);
      // narrow intervals push out more words
      if ($urandom_range(0, 3) == 0) fl = (fh > 8) ? fh - $urandom_range(1, 8) : 0;
      else fl = $urandom_range(0, fh - 1);
      r.cum_high = fh;
      r.cum_low = fl;
      r.bit_value = $urandom_range(0, 1);
      r.zero_prob = (r.cmd == msre_pkg::CMD_BOOL) ? $urandom_range(1, r.total_freq - 1)
                                                  : $urandom_range(1, 32767);
      if ($urandom_range(0, 3) == 0) r.zero_prob = $urandom_range(0, 1) ? 1 : r.zero_prob | 15'h7F00;
      return r;
   endfunction

   function automatic msre_pkg::req_type noise_item();
      msre_pkg::req_type r;
      r = msre_pkg::req_type'({$urandom, $urandom, 2'($urandom)});
      if ($urandom_range(0, 2) != 0) r.cmd = $urandom_range(0, 4);
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      msre_pkg::rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (pending_words.size() == 0) begin
            $error("unexpected word carry_word=%0h last=%0b",
                   rsp_payload.carry_word, rsp_payload.last);
            failures++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_payload.carry_word !== want.carry_word) begin
               $error("carry_word expected %0h actual %0h",
                      want.carry_word, rsp_payload.carry_word);
               failures++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last expected %0b actual %0b", want.last, rsp_payload.last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d words outstanding", pending_words.size());
         $display("FAIL multi_symbol_range_encoder");
         $finish;
      end
   end

   // result side: random stalls, a long hold-off each time one is requested
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 0;
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
         end
         stall = gaps_on ? $urandom_range(0, 3) : 0;
         repeat (stall) begin
            rsp_ready <= 0;
            @(negedge clock);
         end
         rsp_ready <= 1;
         @(negedge clock);
      end
   end

   initial begin
      logic [8:0] none[3];
      msre_pkg::req_type it;
      int seq_len;
      none = '{default: '0};
      low_win = 0;
      range_q = 32'h8000;
      bits_pending = -9;
      ro_mode = 0;

      // directed rows: nothing comes out of the typed ones
      add_row(mk_item(msre_pkg::CMD_FLUSH, 0, 0, 0, 0, 0), 1);
      add_row(mk_item(CMD_RSVD_LO, 15'h7FFF, 16'hFFFF, 16'hFFFF, 1, 15'h7FFF), 1);
      add_row(mk_item(CMD_RSVD_HI, 0, 0, 0, 0, 0), 1);
      add_row(mk_item(msre_pkg::CMD_SYMBOL, 0, 1, 32768, 0, 0), 0);
      add_row(mk_item(msre_pkg::CMD_SYMBOL, 15'h7FFF, 16'h8000, 16'h8000, 0, 0), 0);
      add_row(mk_item(msre_pkg::CMD_SYMBOL, 0, 0, 0, 0, 0), 0);
      add_row(mk_item(msre_pkg::CMD_SYMBOL, 15'h7FFF, 16'hFFFF, 16'hFFFF, 1, 15'h7FFF), 0);
      add_row(mk_item(msre_pkg::CMD_SYMBOL, 500, 100, 20000, 0, 0), 0);
      add_row(mk_item(msre_pkg::CMD_SYMBOL, 16383, 16384, 16384, 0, 0), 0);
      add_row(mk_item(msre_pkg::CMD_SYMBOL_Q15, 0, 16'h8000, 0, 0, 0), 0);
      add_row(mk_item(msre_pkg::CMD_SYMBOL_Q15, 0, 0, 0, 0, 0), 0);
      add_row(mk_item(msre_pkg::CMD_SYMBOL_Q15, 15'h7FFF, 16'hFFFF, 0, 0, 0), 0);
      add_row(mk_item(msre_pkg::CMD_SYMBOL_Q15, 3, 4, 0, 0, 0), 0);
      add_row(mk_item(msre_pkg::CMD_BOOL, 0, 0, 16384, 0, 1), 0);
      add_row(mk_item(msre_pkg::CMD_BOOL, 0, 0, 16384, 1, 15'h7FFF), 0);
      add_row(mk_item(msre_pkg::CMD_BOOL, 0, 0, 16'h8000, 1, 0), 0);
      add_row(mk_item(msre_pkg::CMD_BOOL_Q15, 0, 0, 0, 0, 0), 0);
      add_row(mk_item(msre_pkg::CMD_BOOL_Q15, 0, 0, 0, 1, 15'h7FFF), 0);
      add_row(mk_item(msre_pkg::CMD_BOOL_Q15, 0, 0, 0, 1, 16384), 0);
      add_row(mk_item(msre_pkg::CMD_FLUSH, 15'h7FFF, 16'hFFFF, 16'hFFFF, 1, 15'h7FFF), 0);
      add_row(mk_item(msre_pkg::CMD_FLUSH, 0, 0, 0, 0, 0), 1);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_mode(0);

      foreach (dir_rows[i])
         send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].nwords,
                   dir_rows[i].words);

      // random phases, mode toggled between them, extremes both covered
      for (int phase = 0; phase < 4; phase++) begin
         write_mode(phase[0] ? 0 : 1);
         while (items_sent < 25 + (phase + 1) * 103) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            seq_len = $urandom_range(1, 30);
            for (int k = 0; k < seq_len; k++) begin
               it = ($urandom_range(0, 7) == 0) ? noise_item() : well_formed_item();
               if (phase == 1 && k == 3 && !long_hold) long_hold = 1;
               send_plain(it);
            end
            if ($urandom_range(0, 5) != 0)
               send_plain(mk_item(msre_pkg::CMD_FLUSH, 0, 0, 0, 0, 0));
         end
      end
      send_plain(mk_item(msre_pkg::CMD_FLUSH, 0, 0, 0, 0, 0));
      drain_and_idle();

      $display("covered %0d items (%0d flushes) and %0d result words, both mode settings",
               items_sent, flushes_sent, words_seen);
      if (failures == 0 && pending_words.size() == 0) begin
         $display("PASS multi_symbol_range_encoder");
      end else begin
         $display("FAIL multi_symbol_range_encoder");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/msre_pkg.sv
rtl/msre_ctrl.sv
rtl/msre_datapath.sv
rtl/multi_symbol_range_encoder.sv
tb/sv/testbench.sv
